>>> hw/rtl/dsps_pkg.sv
`default_nettype none
package dsps_pkg;

   localparam int SAMPLE_W    = 12;
   localparam int SLOT_W      = 8;
   localparam int TLEN_W      = 9;
   localparam int PERIOD_W    = 16;
   localparam int CHAN_W      = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   // item operation codes
   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_PUSH    = 2'd1,
      OP_TABLE   = 2'd2,
      OP_CONVERT = 2'd3
   } op_type;

   // control register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CONT_MODE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_FIFO    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_LEN   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_CHAN = 3'd4;

   localparam logic [CHAN_W-1:0] CHAN_ONE   = 2'd1;
   localparam logic [CHAN_W-1:0] CHAN_TWO   = 2'd2;
   localparam logic [CHAN_W-1:0] CHAN_RESET = CHAN_TWO;

   typedef struct packed {
      logic push;
      logic pop;
   } fifo_ctl_type;

   typedef struct packed {
      logic empty;
      logic full;
   } fifo_stat_type;

   typedef struct packed {
      logic write;
      logic play;
   } wave_ctl_type;

endpackage
`default_nettype wire

>>> hw/rtl/dsps_fifo.sv
`default_nettype none
module dsps_fifo
   import dsps_pkg::*;
#(
   parameter int FIFO_DEPTH = 64,
   localparam int PW = $clog2(FIFO_DEPTH),
   localparam int CW = $clog2(FIFO_DEPTH + 1)
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire fifo_ctl_type        ctl,
   input  wire logic [SAMPLE_W-1:0] push_data,
   output logic      [SAMPLE_W-1:0] head,
   output logic      [CW-1:0]       fill_next,
   output fifo_stat_type            stat
);

   logic [SAMPLE_W-1:0] mem [FIFO_DEPTH];

   logic [PW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [PW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [CW-1:0]       fill_ff, fill_in;
   logic [SAMPLE_W-1:0] head_ff;
   logic [PW:0]         rd_inc, wr_inc;

   always_comb begin
      rd_inc = {1'b0, rd_ptr_ff} + 1'b1;
      wr_inc = {1'b0, wr_ptr_ff} + 1'b1;
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      fill_in = fill_ff;
      if (ctl.pop) begin
         rd_ptr_in = (rd_inc == (PW+1)'(FIFO_DEPTH)) ? '0 : rd_inc[PW-1:0];
      end
      if (ctl.push) begin
         wr_ptr_in = (wr_inc == (PW+1)'(FIFO_DEPTH)) ? '0 : wr_inc[PW-1:0];
      end
      if (ctl.push && !ctl.pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (ctl.pop && !ctl.push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // head register always holds the entry at the read pointer, write bypassed
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[wr_ptr_ff] <= push_data;
      end
      head_ff <= (ctl.push && (wr_ptr_ff == rd_ptr_in)) ? push_data : mem[rd_ptr_in];
   end

   assign head       = head_ff;
   assign fill_next  = fill_in;
   assign stat.empty = (fill_ff == '0);
   assign stat.full  = (fill_ff == CW'(FIFO_DEPTH));

endmodule
`default_nettype wire

>>> hw/rtl/dsps_wave.sv
`default_nettype none
module dsps_wave
   import dsps_pkg::*;
#(
   parameter int TABLE_DEPTH = 256,
   localparam int IW = $clog2(TABLE_DEPTH),
   localparam int LW = $clog2(TABLE_DEPTH + 1)
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire wave_ctl_type        ctl,
   input  wire logic [SLOT_W-1:0]   wr_slot,
   input  wire logic [SAMPLE_W-1:0] wr_data,
   input  wire logic [TLEN_W-1:0]   len_cur,
   input  wire logic [TLEN_W-1:0]   len_next,
   output logic      [SAMPLE_W-1:0] head,
   output logic                     playable
);

   logic [SAMPLE_W-1:0] mem [TABLE_DEPTH];

   logic [IW-1:0]       play_ff, play_in;
   logic [SAMPLE_W-1:0] head_ff;
   logic [LW-1:0]       lenc_cur, lenc_next, step;
   logic [IW-1:0]       eff_cur, eff_next, waddr;
   logic                wr_ok;

   function automatic logic [LW-1:0] clamp_len(input logic [TLEN_W-1:0] len);
      return (32'(len) > 32'(TABLE_DEPTH)) ? LW'(TABLE_DEPTH) : LW'(len);
   endfunction

   always_comb begin
      lenc_cur  = clamp_len(len_cur);
      lenc_next = clamp_len(len_next);
      // an index at or past the length restarts at entry 0
      eff_cur   = (LW'(play_ff) >= lenc_cur) ? '0 : play_ff;
      step      = LW'(eff_cur) + 1'b1;
      play_in   = play_ff;
      if (ctl.play) begin
         play_in = (step >= lenc_cur) ? '0 : IW'(step);
      end
      eff_next  = (LW'(play_in) >= lenc_next) ? '0 : play_in;
      wr_ok     = ctl.write && (32'(wr_slot) < 32'(TABLE_DEPTH));
      waddr     = IW'(wr_slot);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         play_ff <= '0;
      end else begin
         play_ff <= play_in;
      end
   end

   // prefetch the entry that plays next, write bypassed
   always_ff @(posedge clock) begin
      if (wr_ok) begin
         mem[waddr] <= wr_data;
      end
      head_ff <= (wr_ok && (waddr == eff_next)) ? wr_data : mem[eff_next];
   end

   assign head     = head_ff;
   assign playable = (lenc_cur != '0);

endmodule
`default_nettype wire

>>> hw/rtl/dac_sample_playback_sequencer.sv
`default_nettype none
// dac sample playback sequencer: takes one request word per clock and returns one
// response word per request, in order, as long as the response channel does not
// stall. every word passes an input register and a result register, and the fifo
// and table state is updated as a word moves between them; a full result register
// that rsp_ready does not free holds the input register and the request channel.
// both sample stores keep a registered head entry (fifo entry
// at the read pointer, table entry that plays next) that is refetched every
// cycle with write bypass, so a due sample is available without a read stall.
// no clearing pass is needed after reset. the user must write control registers
// through the csr port only while no request is in flight; the block does not enforce it.
module dac_sample_playback_sequencer
   import dsps_pkg::*;
#(
   parameter int FIFO_DEPTH  = 64,
   parameter int TABLE_DEPTH = 256
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [1:0]            req_op,
   input  wire logic [SAMPLE_W-1:0]   req_sample_value,
   input  wire logic [SLOT_W-1:0]     req_table_slot,
   // response channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_converted,
   output logic [CHAN_W-1:0]          rsp_channel,
   output logic [SAMPLE_W-1:0]        rsp_dac_value,
   output logic [$clog2(FIFO_DEPTH+1)-1:0] rsp_fifo_count,
   output logic                       rsp_push_dropped,
   output logic                       rsp_underrun,
   // control register writes
   input  wire logic                  csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   localparam int CW = $clog2(FIFO_DEPTH + 1);

   // input register
   logic                in_vld_ff, in_vld_in;
   op_type              in_op_ff;
   logic [SAMPLE_W-1:0] in_val_ff;
   logic [SLOT_W-1:0]   in_slot_ff;

   // result register
   logic                out_vld_ff, out_vld_in;
   logic                conv_ff;
   logic [CHAN_W-1:0]   chan_ff;
   logic [SAMPLE_W-1:0] value_ff;
   logic [CW-1:0]       count_ff;
   logic                drop_ff;
   logic                under_ff;

   // control registers
   logic                cont_ff, cont_in;
   logic                src_fifo_ff, src_fifo_in;
   logic [TLEN_W-1:0]   tlen_ff, tlen_in;
   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [CHAN_W-1:0]   chan_sel_ff, chan_sel_in;

   // playback state
   logic [PERIOD_W-1:0] tick_ff, tick_in;
   logic [SAMPLE_W-1:0] last_ff, last_in;

   logic                proc;
   logic                due;
   logic                conv, dropped, under;
   logic [SAMPLE_W-1:0] value;
   logic [PERIOD_W:0]   tick_inc, period_eff;
   logic                do_push, do_pop, do_write, do_play;

   fifo_ctl_type        fifo_ctl;
   fifo_stat_type       fifo_stat;
   logic [SAMPLE_W-1:0] fifo_head;
   logic [CW-1:0]       fifo_fill_next;

   wave_ctl_type        wave_ctl;
   logic [SAMPLE_W-1:0] wave_head;
   logic                wave_playable;

   // the word in the input register moves on when the result slot frees up
   assign proc      = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || proc;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_valid && req_ready) begin
         in_vld_in = 1'b1;
      end else if (proc) begin
         in_vld_in = 1'b0;
      end
      out_vld_in = out_vld_ff;
      if (proc) begin
         out_vld_in = 1'b1;
      end else if (rsp_ready) begin
         out_vld_in = 1'b0;
      end
   end

   // per-word processing
   always_comb begin
      conv     = 1'b0;
      dropped  = 1'b0;
      under    = 1'b0;
      value    = '0;
      due      = 1'b0;
      do_push  = 1'b0;
      do_pop   = 1'b0;
      do_write = 1'b0;
      do_play  = 1'b0;
      last_in  = last_ff;
      tick_in  = tick_ff;
      tick_inc = {1'b0, tick_ff} + 1'b1;
      period_eff = (period_ff == '0) ? (PERIOD_W+1)'(1) : {1'b0, period_ff};
      case (in_op_ff)
         OP_TICK: begin
            // ticks only count in continuous mode
            if (cont_ff) begin
               if (tick_inc >= period_eff) begin
                  tick_in = '0;
                  due     = 1'b1;
               end else begin
                  tick_in = tick_inc[PERIOD_W-1:0];
               end
            end
         end
         OP_PUSH: begin
            if (fifo_stat.full) begin
               dropped = 1'b1;
            end else begin
               do_push = 1'b1;
            end
         end
         OP_TABLE: begin
            do_write = 1'b1;
         end
         OP_CONVERT: begin
            conv  = 1'b1;
            value = in_val_ff;
         end
         default: begin
            conv = 1'b0;
         end
      endcase
      if (due) begin
         if (src_fifo_ff) begin
            conv = 1'b1;
            if (fifo_stat.empty) begin
               // underrun repeats the last played sample
               under = 1'b1;
               value = last_ff;
            end else begin
               do_pop  = 1'b1;
               value   = fifo_head;
               last_in = fifo_head;
            end
         end else if (wave_playable) begin
            do_play = 1'b1;
            conv    = 1'b1;
            value   = wave_head;
            last_in = wave_head;
         end
      end
   end

   assign fifo_ctl.push  = proc && do_push;
   assign fifo_ctl.pop   = proc && do_pop;
   assign wave_ctl.write = proc && do_write;
   assign wave_ctl.play  = proc && do_play;

   // control register writes; mode and period writes restart the divider
   always_comb begin
      cont_in     = cont_ff;
      src_fifo_in = src_fifo_ff;
      tlen_in     = tlen_ff;
      period_in   = period_ff;
      chan_sel_in = chan_sel_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_CONT_MODE:   cont_in     = csr_data[0];
            CSR_SRC_FIFO:    src_fifo_in = csr_data[0];
            CSR_TABLE_LEN:   tlen_in     = csr_data[TLEN_W-1:0];
            CSR_PERIOD:      period_in   = csr_data[PERIOD_W-1:0];
            CSR_ACTIVE_CHAN: begin
               if (csr_data[CHAN_W-1:0] == CHAN_ONE || csr_data[CHAN_W-1:0] == CHAN_TWO) begin
                  chan_sel_in = csr_data[CHAN_W-1:0];
               end
            end
            default: begin
               cont_in = cont_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff   <= 1'b0;
         out_vld_ff  <= 1'b0;
         cont_ff     <= 1'b0;
         src_fifo_ff <= 1'b0;
         tlen_ff     <= '0;
         period_ff   <= PERIOD_W'(1);
         chan_sel_ff <= CHAN_RESET;
         tick_ff     <= '0;
         last_ff     <= '0;
      end else begin
         in_vld_ff   <= in_vld_in;
         out_vld_ff  <= out_vld_in;
         cont_ff     <= cont_in;
         src_fifo_ff <= src_fifo_in;
         tlen_ff     <= tlen_in;
         period_ff   <= period_in;
         chan_sel_ff <= chan_sel_in;
         if (csr_write_en && (csr_index == CSR_CONT_MODE || csr_index == CSR_PERIOD)) begin
            tick_ff <= '0;
         end else if (proc) begin
            tick_ff <= tick_in;
         end
         if (proc) begin
            last_ff <= last_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_op_ff   <= op_type'(req_op);
         in_val_ff  <= req_sample_value;
         in_slot_ff <= req_table_slot;
      end
      if (proc) begin
         conv_ff  <= conv;
         chan_ff  <= chan_sel_ff;
         value_ff <= value;
         count_ff <= fifo_fill_next;
         drop_ff  <= dropped;
         under_ff <= under;
      end
   end

   dsps_fifo #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .ctl       (fifo_ctl),
      .push_data (in_val_ff),
      .head      (fifo_head),
      .fill_next (fifo_fill_next),
      .stat      (fifo_stat)
   );

   dsps_wave #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_wave (
      .clock    (clock),
      .reset    (reset),
      .ctl      (wave_ctl),
      .wr_slot  (in_slot_ff),
      .wr_data  (in_val_ff),
      .len_cur  (tlen_ff),
      .len_next (tlen_in),
      .head     (wave_head),
      .playable (wave_playable)
   );

   assign rsp_valid        = out_vld_ff;
   assign rsp_converted    = conv_ff;
   assign rsp_channel      = chan_ff;
   assign rsp_dac_value    = value_ff;
   assign rsp_fifo_count   = count_ff;
   assign rsp_push_dropped = drop_ff;
   assign rsp_underrun     = under_ff;

   // an underrun is always a conversion from an empty fifo
   a_underrun_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_underrun |-> rsp_converted && (rsp_fifo_count == '0))
      else $error("underrun reported with samples still queued");

   // a dropped push only happens at full occupancy
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_push_dropped |-> (rsp_fifo_count == CW'(FIFO_DEPTH)))
      else $error("push dropped while fifo not full");

   a_idle_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_converted |-> (rsp_dac_value == '0))
      else $error("dac value nonzero without conversion");

   a_chan_legal: assert property (@(posedge clock) disable iff (reset)
      (chan_sel_ff == CHAN_ONE) || (chan_sel_ff == CHAN_TWO))
      else $error("active channel left the legal set");

   // a divider restart from the csr port clears the tick count next cycle
   a_tick_restart: assert property (@(posedge clock) disable iff (reset)
      csr_write_en && (csr_index == CSR_PERIOD) |=> (tick_ff == '0))
      else $error("tick count not cleared by period write");

endmodule
`default_nettype wire
